### design/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg: shared definitions of the pairwise float sum block
// Constants, the sequencer state type and the adder request and response.
// ----------------------------------------------------------------------------
`default_nettype none

package pfs_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_COUNT = 65536;
    localparam int DEF_LEAF_SIZE = 128;

    // Lanes in a leaf and the canonical quiet NaN.
    localparam int          GROUP     = 8;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    // Register index of the count register.
    localparam logic REG_COUNT = 1'b0;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DESC,
        S_PROC,
        S_WAIT,
        S_POST,
        S_NEXT,
        S_COMB,
        S_FOLD,
        S_OUT
    } t_state;

    // Where a returning adder result is written.
    typedef enum logic [2:0] {
        D_LANE,
        D_LEAF,
        D_QUE,
        D_CFIN,
        D_V
    } t_dest;

    // Request to and response from the shared adder.
    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } t_add_req;

    typedef struct packed {
        logic        done;
        logic [31:0] sum;
    } t_add_rsp;

endpackage

`default_nettype wire

### design/pairwise_float_sum.sv
// ----------------------------------------------------------------------------
// pairwise_float_sum: pairwise summation of binary32 samples
// Sums a configured number of samples in pairwise order with one shared adder.
// ----------------------------------------------------------------------------
// Usage: write the sample count to register 0 over the APB port, then send
// the samples one word each on the slave stream in index order. After the last
// sample of a sum one word carrying the total appears on the master stream.
// Every add goes through one four-stage binary32 adder, and the sequencer
// waits for each result before the next add. Each sample is accepted,
// dispatched, added and then passes the post and next-position states;
// the first eight samples of a leaf of at least eight samples fill the
// lanes and need no add. At the end of the lane pass of each leaf of up to
// LEAF_SIZE samples the lanes are summed by seven tree adds, and each
// fold of a left partial into a right one adds one more add.
// The total is loaded into the output register after the last sample's
// final fold. The slave side is not ready while a sample is at work.
// Reset is synchronous and active low; it sets the count to one and
// empties the sequencer and output register, with no clearing pass.
// A stalled receiver holds the total in the output register; the block can
// take the samples of the next sum meanwhile and waits only if that sum
// finishes before the previous total has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_float_sum
    import pfs_pkg::*;
#(
    parameter int MAX_COUNT = DEF_MAX_COUNT,
    parameter int LEAF_SIZE = DEF_LEAF_SIZE
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] sample
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata    // [31:0] total
);

    logic [16:0] r_count;
    t_add_req    add_req;
    t_add_rsp    add_rsp;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 17'd1;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_COUNT)) begin
            r_count <= i_pwdata[16:0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_COUNT) ? {15'd0, r_count} : 32'd0;

    // Sequencer and shared adder.
    pfs_ctrl #(
        .MAX_COUNT (MAX_COUNT),
        .LEAF_SIZE (LEAF_SIZE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_count    (r_count),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_req      (add_req),
        .i_rsp      (add_rsp)
    );

    pfs_fadd u_fadd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (add_req),
        .o_rsp   (add_rsp)
    );

`ifndef SYNTH
    // An adder result never arrives while the block waits for a sample.
    a_no_rsp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        add_rsp.done |-> !o_s_tready)
        else $error("adder result while idle");

    // Adds are issued one at a time, never in consecutive cycles.
    a_spaced_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        add_req.start |=> !add_req.start)
        else $error("back-to-back adder requests");

    // No sample is taken while an add is in flight.
    a_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        add_req.start |=> !o_s_tready)
        else $error("ready while adding");

    // A NaN total is always the canonical quiet NaN.
    a_canon_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[30:23] == 8'hFF) && (o_m_tdata[22:0] != 23'd0))
        |-> (o_m_tdata == CANON_NAN))
        else $error("non-canonical NaN total");
`endif

endmodule

`default_nettype wire

### design/pfs_fadd.sv
// ----------------------------------------------------------------------------
// pfs_fadd: four-stage binary32 adder
// Round to nearest even, subnormals kept, any NaN given as canonical NaN.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_fadd
    import pfs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_add_req i_req,
    output t_add_rsp      o_rsp
);

    // Leading zeros of a 27-bit word.
    function automatic logic [4:0] clz27(input logic [26:0] x);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (x[i]) begin
                n = 5'(26 - i);
            end
        end
        return n;
    endfunction

    // Stage registers.
    logic        r1_v, r2_v, r3_v, r4_v;
    logic        r1_spec, r2_spec, r3_spec;
    logic [31:0] r1_sval, r2_sval, r3_sval, r4_sum;
    logic        r1_sign, r2_sign, r3_sign;
    logic        r1_sub;
    logic [9:0]  r1_exp, r2_exp, r3_e;
    logic [26:0] r1_big, r1_al, r3_m;
    logic [27:0] r2_sum;

    // Stage one: specials, operand order and alignment.
    logic        nan_a, nan_b, inf_a, inf_b, swap;
    logic [31:0] big, sml;
    logic [7:0]  eb, es, d;
    logic [4:0]  dc;
    logic [49:0] ext;
    logic        n1_spec;
    logic [31:0] n1_sval;

    always_comb begin
        nan_a = (i_req.a[30:23] == 8'hFF) && (i_req.a[22:0] != 23'd0);
        nan_b = (i_req.b[30:23] == 8'hFF) && (i_req.b[22:0] != 23'd0);
        inf_a = (i_req.a[30:23] == 8'hFF) && (i_req.a[22:0] == 23'd0);
        inf_b = (i_req.b[30:23] == 8'hFF) && (i_req.b[22:0] == 23'd0);
        n1_spec = nan_a || nan_b || inf_a || inf_b;
        if (nan_a || nan_b || (inf_a && inf_b && (i_req.a[31] != i_req.b[31]))) begin
            n1_sval = CANON_NAN;
        end else if (inf_a) begin
            n1_sval = i_req.a;
        end else begin
            n1_sval = i_req.b;
        end
        swap = i_req.b[30:0] > i_req.a[30:0];
        big  = swap ? i_req.b : i_req.a;
        sml  = swap ? i_req.a : i_req.b;
        eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d    = eb - es;
        dc   = (d > 8'd31) ? 5'd31 : d[4:0];
        ext  = {(sml[30:23] != 8'd0), sml[22:0], 26'd0} >> dc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_req.start;
        end
        r1_spec <= n1_spec;
        r1_sval <= n1_sval;
        r1_sign <= big[31];
        r1_sub  <= i_req.a[31] ^ i_req.b[31];
        r1_exp  <= {2'b00, eb};
        r1_big  <= {(big[30:23] != 8'd0), big[22:0], 3'b000};
        r1_al   <= {ext[49:24], |ext[23:0]};
    end

    // Stage two: magnitude add or subtract.
    logic [27:0] n2_sum;

    always_comb begin
        if (r1_sub) begin
            n2_sum = {1'b0, r1_big} - {1'b0, r1_al};
        end else begin
            n2_sum = {1'b0, r1_big} + {1'b0, r1_al};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_spec <= r1_spec;
        r2_sval <= r1_sval;
        r2_sum  <= n2_sum;
        // An exact cancellation gives +0.
        r2_sign <= (r1_sub && (n2_sum == 28'd0)) ? 1'b0 : r1_sign;
        r2_exp  <= r1_exp;
    end

    // Stage three: normalise, stopping at the subnormal exponent.
    logic [4:0]  lz, sh;
    logic [9:0]  lim;
    logic [26:0] n3_m;
    logic [9:0]  n3_e;

    always_comb begin
        lz  = clz27(r2_sum[26:0]);
        lim = r2_exp - 10'd1;
        sh  = ({5'd0, lz} < lim) ? lz : lim[4:0];
        if (r2_sum[27]) begin
            n3_m = {r2_sum[27:2], r2_sum[1] | r2_sum[0]};
            n3_e = r2_exp + 10'd1;
        end else begin
            n3_m = r2_sum[26:0] << sh;
            n3_e = r2_exp - {5'd0, sh};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_spec <= r2_spec;
        r3_sval <= r2_sval;
        r3_m    <= n3_m;
        r3_e    <= n3_e;
        r3_sign <= r2_sign;
    end

    // Stage four: round and pack; a carry runs into the exponent.
    logic        inc;
    logic [7:0]  ef;
    logic [30:0] mag;
    logic [31:0] n4_sum;

    always_comb begin
        inc = r3_m[2] & (r3_m[1] | r3_m[0] | r3_m[3]);
        ef  = r3_m[26] ? r3_e[7:0] : 8'd0;
        mag = {ef, r3_m[25:3]} + {30'd0, inc};
        if (r3_spec) begin
            n4_sum = r3_sval;
        end else if (r3_m[26] && (r3_e >= 10'd255)) begin
            n4_sum = {r3_sign, 8'hFF, 23'd0};
        end else begin
            n4_sum = {r3_sign, mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_sum <= n4_sum;
    end

    assign o_rsp = '{done: r4_v, sum: r4_sum};

endmodule

`default_nettype wire

### design/pfs_ctrl.sv
// ----------------------------------------------------------------------------
// pfs_ctrl: sequencer of the pairwise sum
// Splits the range, runs the lanes and the leaf tail, folds partial sums.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_ctrl
    import pfs_pkg::*;
#(
    parameter int MAX_COUNT = DEF_MAX_COUNT,
    parameter int LEAF_SIZE = DEF_LEAF_SIZE
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [16:0] i_count,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // sample
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // total
    output t_add_req         o_req,
    input  wire t_add_rsp    i_rsp
);

    localparam int LW  = $clog2(MAX_COUNT + 1);
    localparam int LL  = $clog2(LEAF_SIZE + 1);
    localparam int SD  = $clog2(MAX_COUNT) + 1;
    localparam int SW  = $clog2(SD + 1);
    localparam int TW  = $clog2(SD);

    t_state        r_state, n_state;
    t_dest         r_dest, n_dest;
    logic [31:0]   r_x, n_x;
    logic [LW-1:0] r_len, n_len;
    logic [SW-1:0] r_level, n_level;
    logic [LW-1:0] r_pending [SD];
    logic [LW-1:0] n_pending [SD];
    logic [31:0]   r_partial [SD];
    logic [31:0]   n_partial [SD];
    logic [31:0]   r_lane [GROUP];
    logic [31:0]   n_lane [GROUP];
    logic [31:0]   r_leaf, n_leaf;
    logic [31:0]   r_v, n_v;
    logic [LL-1:0] r_leaf_len, n_leaf_len;
    logic [LL-1:0] r_pos, n_pos;
    logic          r_in_sum, n_in_sum;
    logic          r_first, n_first;
    logic [3:0]    r_qlen, n_qlen;
    logic          r_ovalid, n_ovalid;
    logic [31:0]   r_odata, n_odata;

    // Shared conditions.
    logic          accept, lt8, split, last_pos, comb_due, v_nan;
    logic [LL-1:0] full, pos1;
    logic [TW-1:0] top;
    logic [31:0]   n32;
    logic [LW-1:0] half;

    always_comb begin
        accept   = i_s_tvalid && (r_state == S_IDLE);
        lt8      = 32'(r_leaf_len) < 32'(GROUP);
        full     = {r_leaf_len[LL-1:3], 3'b000};
        pos1     = r_pos + LL'(1);
        last_pos = !(pos1 < r_leaf_len);
        comb_due = !lt8 && (pos1 == full);
        split    = (32'(r_len) > 32'(LEAF_SIZE)) && (32'(r_level) < 32'(SD));
        half     = LW'((r_len >> 4) << 3);
        top      = TW'(r_level - SW'(1));
        v_nan    = (r_v[30:23] == 8'hFF) && (r_v[22:0] != 23'd0);
        if (i_count == 17'd0) begin
            n32 = 32'd1;
        end else if (32'(i_count) > 32'(MAX_COUNT)) begin
            n32 = 32'(MAX_COUNT);
        end else begin
            n32 = 32'(i_count);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = r_in_sum ? S_PROC : S_DESC;
                end
            end
            S_DESC: begin
                if (!split) begin
                    n_state = r_first ? S_PROC : S_IDLE;
                end
            end
            S_PROC: begin
                if (!lt8 && (32'(r_pos) < 32'(GROUP))) begin
                    n_state = S_POST;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_rsp.done) begin
                    unique case (r_dest)
                        D_LANE, D_LEAF: n_state = S_POST;
                        D_QUE:          n_state = S_COMB;
                        D_CFIN:         n_state = S_NEXT;
                        D_V:            n_state = S_FOLD;
                        default:        n_state = S_FOLD;
                    endcase
                end
            end
            S_POST: n_state = comb_due ? S_COMB : S_NEXT;
            S_NEXT: n_state = last_pos ? S_FOLD : S_IDLE;
            S_COMB: n_state = S_WAIT;
            S_FOLD: begin
                if (r_level == SW'(0)) begin
                    n_state = S_OUT;
                end else if (r_pending[top] != LW'(0)) begin
                    n_state = S_DESC;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_OUT: begin
                if (!r_ovalid) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and adder requests.
    always_comb begin
        n_dest     = r_dest;
        n_x        = r_x;
        n_len      = r_len;
        n_level    = r_level;
        n_pending  = r_pending;
        n_partial  = r_partial;
        n_lane     = r_lane;
        n_leaf     = r_leaf;
        n_v        = r_v;
        n_leaf_len = r_leaf_len;
        n_pos      = r_pos;
        n_in_sum   = r_in_sum;
        n_first    = r_first;
        n_qlen     = r_qlen;
        n_ovalid   = r_ovalid && !i_m_tready;
        n_odata    = r_odata;
        o_req      = '{start: 1'b0, a: r_leaf, b: r_x};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_x = i_s_tdata;
                    if (!r_in_sum) begin
                        n_len    = LW'(n32);
                        n_level  = SW'(0);
                        n_in_sum = 1'b1;
                        n_first  = 1'b1;
                    end
                end
            end
            S_DESC: begin
                if (split) begin
                    n_pending[TW'(r_level)] = r_len - half;
                    n_level = r_level + SW'(1);
                    n_len   = half;
                end else begin
                    n_leaf_len = LL'(r_len);
                    n_pos      = LL'(0);
                    n_leaf     = 32'd0;
                end
            end
            S_PROC: begin
                if (lt8 || !(r_pos < full)) begin
                    o_req  = '{start: 1'b1, a: r_leaf, b: r_x};
                    n_dest = D_LEAF;
                end else if (32'(r_pos) < 32'(GROUP)) begin
                    n_lane[r_pos[2:0]] = r_x;
                end else begin
                    o_req  = '{start: 1'b1, a: r_lane[r_pos[2:0]], b: r_x};
                    n_dest = D_LANE;
                end
            end
            S_WAIT: begin
                if (i_rsp.done) begin
                    unique case (r_dest)
                        D_LANE:         n_lane[r_pos[2:0]] = i_rsp.sum;
                        D_LEAF, D_CFIN: n_leaf = i_rsp.sum;
                        D_QUE: begin
                            n_lane[r_qlen[2:0]] = i_rsp.sum;
                            n_qlen = r_qlen + 4'd1;
                        end
                        D_V:            n_v = i_rsp.sum;
                        default:        n_v = i_rsp.sum;
                    endcase
                end
            end
            S_POST: begin
                // The lane tree runs as a queue: the front pair is added and
                // the sum goes to the back, giving the fixed pairing order.
                n_qlen = 4'(GROUP);
            end
            S_NEXT: begin
                n_pos = pos1;
                n_v   = r_leaf;
            end
            S_COMB: begin
                o_req = '{start: 1'b1, a: r_lane[0], b: r_lane[1]};
                if (r_qlen == 4'd2) begin
                    n_dest = D_CFIN;
                end else begin
                    n_dest = D_QUE;
                    for (int i = 0; i < GROUP - 2; i++) begin
                        n_lane[i] = r_lane[i + 2];
                    end
                end
                n_qlen = r_qlen - 4'd2;
            end
            S_FOLD: begin
                if (r_level != SW'(0)) begin
                    if (r_pending[top] != LW'(0)) begin
                        n_partial[top] = r_v;
                        n_len          = r_pending[top];
                        n_pending[top] = LW'(0);
                        n_first        = 1'b0;
                    end else begin
                        o_req   = '{start: 1'b1, a: r_partial[top], b: r_v};
                        n_dest  = D_V;
                        n_level = SW'(top);
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid) begin
                    n_ovalid = 1'b1;
                    n_odata  = v_nan ? CANON_NAN : r_v;
                    n_in_sum = 1'b0;
                end
            end
            default: n_in_sum = 1'b0;
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_level    <= '0;
            r_in_sum   <= 1'b0;
            r_first    <= 1'b0;
            r_ovalid   <= 1'b0;
            r_pos      <= '0;
            r_leaf_len <= '0;
            r_qlen     <= '0;
        end else begin
            r_state    <= n_state;
            r_level    <= n_level;
            r_in_sum   <= n_in_sum;
            r_first    <= n_first;
            r_ovalid   <= n_ovalid;
            r_pos      <= n_pos;
            r_leaf_len <= n_leaf_len;
            r_qlen     <= n_qlen;
        end
        r_dest    <= n_dest;
        r_x       <= n_x;
        r_len     <= n_len;
        r_pending <= n_pending;
        r_partial <= n_partial;
        r_lane    <= n_lane;
        r_leaf    <= n_leaf;
        r_v       <= n_v;
        r_odata   <= n_odata;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule

`default_nettype wire
